// ----- rtl/pedl_pkg.sv -----
// ----------------------------------------------------------------------------
// pedl_pkg
// Shared codes and types of the palette entry to display lookup block.
// ----------------------------------------------------------------------------
package pedl_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_INVERT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_BYTES  = 2'd2;

	localparam int unsigned CFG_DATA_W = 3;

	// Screen depth codes
	localparam logic [2:0] MODE_1BPP  = 3'd0;
	localparam logic [2:0] MODE_2BPP  = 3'd1;
	localparam logic [2:0] MODE_4BPP  = 3'd2;
	localparam logic [2:0] MODE_8BPP  = 3'd3;
	localparam logic [2:0] MODE_12BPP = 3'd4;
	localparam logic [2:0] MODE_16BPP = 3'd5;

	// Kind of work queued for the back end
	localparam logic [1:0] KIND_GRAY1  = 2'd0;
	localparam logic [1:0] KIND_GRAY2  = 2'd1;
	localparam logic [1:0] KIND_GRAY4  = 2'd2;
	localparam logic [1:0] KIND_DIRECT = 2'd3;

	// Lightness above this is treated as light in 1 bpp mode
	localparam logic [7:0] GRAY1_THRESHOLD = 8'd160;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  level;
		logic [15:0] word;
	} pedl_entry_t;

endpackage

// ----- rtl/pedl_front.sv -----
// ----------------------------------------------------------------------------
// pedl_front
// Holds the configuration registers, classifies each palette entry and
// computes either its gray level or its packed direct-colour word.
// ----------------------------------------------------------------------------
module pedl_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pedl_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pedl_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [7:0]                            red,
	input  logic [7:0]                            green,
	input  logic [7:0]                            blue,
	output logic                                  emits,
	output pedl_pkg::pedl_entry_t                 entry
);

	logic [2:0] depth_mode_q;
	logic       gray_invert_q;
	logic       swap_bytes_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= pedl_pkg::MODE_16BPP;
			gray_invert_q <= 1'b0;
			swap_bytes_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pedl_pkg::CFG_DEPTH_MODE:  depth_mode_q  <= cfg_data;
				pedl_pkg::CFG_GRAY_INVERT: gray_invert_q <= cfg_data[0];
				pedl_pkg::CFG_SWAP_BYTES:  swap_bytes_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [7:0]  hi;
	logic [7:0]  lo;
	logic [8:0]  sum;
	logic [7:0]  gray;
	logic [15:0] packed_word;

	always_comb begin
		hi = red;
		lo = red;
		if (green < lo) lo = green;
		if (green > hi) hi = green;
		if (blue < lo) lo = blue;
		if (blue > hi) hi = blue;
		sum  = {1'b0, hi} + {1'b0, lo};
		gray = sum[8:1];
	end

	always_comb begin
		emits       = 1'b1;
		entry.kind  = pedl_pkg::KIND_DIRECT;
		entry.level = 4'd0;
		entry.word  = 16'd0;
		packed_word = 16'd0;
		case (depth_mode_q)
			pedl_pkg::MODE_1BPP: begin
				entry.kind  = pedl_pkg::KIND_GRAY1;
				entry.level = {3'd0, (gray > pedl_pkg::GRAY1_THRESHOLD) == gray_invert_q};
			end
			pedl_pkg::MODE_2BPP: begin
				entry.kind  = pedl_pkg::KIND_GRAY2;
				entry.level = {2'd0, gray_invert_q ? gray[7:6] : ~gray[7:6]};
			end
			pedl_pkg::MODE_4BPP: begin
				entry.kind  = pedl_pkg::KIND_GRAY4;
				entry.level = gray_invert_q ? gray[7:4] : ~gray[7:4];
			end
			pedl_pkg::MODE_12BPP: begin
				packed_word = {4'd0, red[7:4], green[7:4], blue[7:4]};
				entry.word  = swap_bytes_q ? {packed_word[7:0], packed_word[15:8]}
				                           : packed_word;
			end
			pedl_pkg::MODE_16BPP: begin
				packed_word = {red[7:3], green[7:2], blue[7:3]};
				entry.word  = swap_bytes_q ? {packed_word[7:0], packed_word[15:8]}
				                           : packed_word;
			end
			default: begin
				// 8 bpp and unused codes produce nothing.
				emits = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/pedl_queue.sv -----
// ----------------------------------------------------------------------------
// pedl_queue
// Short first-in first-out queue of classified entries between the front
// and back ends.
// ----------------------------------------------------------------------------
module pedl_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pedl_pkg::pedl_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output pedl_pkg::pedl_entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pedl_pkg::pedl_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/pedl_back.sv -----
// ----------------------------------------------------------------------------
// pedl_back
// Expands each queued entry into its result words, one per cycle while m_tready
// does not stall the output register, into that output register.
// ----------------------------------------------------------------------------
module pedl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  pedl_pkg::pedl_entry_t head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // lookup_word[15:0]
	output logic                  m_tlast   // last_of_run
);

	logic [2:0]  slot_q;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tlast_q;

	logic        issue;
	logic        last;
	logic [7:0]  gray_byte;
	logic [15:0] result;

	assign issue = head_valid && (!m_tvalid_q || m_tready);

	// The slot counter picks the pixel position, most significant first.
	always_comb begin
		gray_byte = 8'd0;
		last      = 1'b1;
		case (head.kind)
			pedl_pkg::KIND_GRAY1: begin
				gray_byte = {7'd0, head.level[0]} << (3'd7 - slot_q);
				last      = (slot_q == 3'd7);
			end
			pedl_pkg::KIND_GRAY2: begin
				gray_byte = {6'd0, head.level[1:0]} << {(2'd3 - slot_q[1:0]), 1'b0};
				last      = (slot_q[1:0] == 2'd3);
			end
			pedl_pkg::KIND_GRAY4: begin
				gray_byte = slot_q[0] ? {4'd0, head.level} : {head.level, 4'd0};
				last      = slot_q[0];
			end
			default: begin
				gray_byte = 8'd0;
				last      = 1'b1;
			end
		endcase
		result = (head.kind == pedl_pkg::KIND_DIRECT) ? head.word : {8'd0, gray_byte};
	end

	assign pop = issue && last;

	always_ff @(posedge clk) begin
		if (issue) begin
			m_tdata_q <= result;
			m_tlast_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (issue) begin
				m_tvalid_q <= 1'b1;
				slot_q     <= last ? 3'd0 : slot_q + 3'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- rtl/palette_entry_to_display_lookup.sv -----
// ----------------------------------------------------------------------------
// palette_entry_to_display_lookup
// Turns palette entries into gray-level pixel bytes or packed RGB444/RGB565
// words for the configured screen depth.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  red, green, blue
//  m_       out        m_tvalid / m_tready  lookup_word, last_of_run (tlast)
//  cfg_     in         cfg_valid / cfg_ready register index, write data
//
// One result leaves per cycle while m_tready does not stall the output
// register: an entry gives 8, 4 or 2 words in 1, 2 or 4 bpp mode, one word
// in 12 and 16 bpp mode, and none in 8 bpp or unused modes, stepped by the
// slot counter in the back end. Entries are taken while the queue has room,
// also while a result waits on m_tready. Reset leaves the queue empty and
// the registers at 16 bpp, gray invert flag clear, no byte swap.
// ----------------------------------------------------------------------------
module palette_entry_to_display_lookup #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // lookup_word[15:0]
	output logic                              m_tlast,   // last_of_run
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pedl_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pedl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                  emits;
	pedl_pkg::pedl_entry_t entry;
	logic                  full;
	logic                  pop;
	logic                  head_valid;
	pedl_pkg::pedl_entry_t head;
	logic                  push;

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready && emits;

	pedl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.emits     (emits),
		.entry     (entry)
	);

	pedl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (head_valid),
		.head       (head)
	);

	pedl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for palette_entry_to_display_lookup.
// A queue-fed driver offers palette entries on the input stream and predicts
// the lookup words for each transfer from its own copy of the registers. A
// monitor compares every output transfer with the oldest predicted word.
// Register settings change only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned IDLE_PCT       = 32;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_ENTRIES  = 44;
	localparam int unsigned SILENT_ENTRIES = 8;

	localparam logic [7:0]                       LIGHT_THRESHOLD  = 8'd160;
	localparam logic [pedl_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam logic [2:0]                       MODE_UNUSED_A    = 3'd6;
	localparam logic [2:0]                       MODE_UNUSED_B    = 3'd7;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} palette_entry_t;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} lookup_result_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [23:0]                      s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [15:0]                      m_tdata;          // lookup_word[15:0]
	logic                             m_tlast;          // last_of_run
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [pedl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [pedl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	// Register copy used for prediction, kept in step with accepted writes
	logic [2:0] depth_cfg;
	logic       invert_cfg;
	logic       swap_cfg;

	palette_entry_t entry_q[$];
	lookup_result_t lookup_expect_q[$];
	lookup_result_t result_due;

	int unsigned entries_queued = 0;
	int unsigned entries_taken  = 0;
	int unsigned words_checked  = 0;
	int unsigned mismatches     = 0;
	int unsigned settings_used  = 0;
	int unsigned stall_cycles   = 0;
	int unsigned mode_entries[8];
	int unsigned hold_req       = 0;
	int unsigned hold_served    = 0;
	int unsigned hold_left      = 0;
	logic        steady         = 1'b0;

	palette_entry_to_display_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the lookup words that one palette entry produces under the
	// current register copy and appends them to the expectation queue.
	function automatic void predict_lookup(palette_entry_t e);
		logic [7:0]  hi, lo, gray;
		logic [3:0]  level;
		logic [15:0] word;
		int          bits, slots, k;
		hi = e.red;
		lo = e.red;
		if (e.green > hi) hi = e.green;
		if (e.green < lo) lo = e.green;
		if (e.blue > hi) hi = e.blue;
		if (e.blue < lo) lo = e.blue;
		gray = 8'((9'(hi) + 9'(lo)) >> 1);
		mode_entries[depth_cfg]++;
		case (depth_cfg)
			pedl_pkg::MODE_1BPP, pedl_pkg::MODE_2BPP, pedl_pkg::MODE_4BPP: begin
				if (depth_cfg == pedl_pkg::MODE_1BPP) begin
					// Uninverted, a light entry gives level 0; the invert flag flips it.
					bits = 1;
					level = ((gray > LIGHT_THRESHOLD) == invert_cfg) ? 4'd1 : 4'd0;
				end else if (depth_cfg == pedl_pkg::MODE_2BPP) begin
					bits = 2;
					level = {2'b00, gray[7:6]};
					if (!invert_cfg) level = 4'd3 - level;
				end else begin
					bits = 4;
					level = gray[7:4];
					if (!invert_cfg) level = 4'd15 - level;
				end
				slots = 8 / bits;
				for (k = 0; k < slots; k++) begin
					word = 16'(level) << (8 - bits * (k + 1));
					lookup_expect_q.push_back('{word: word, last: (k + 1 == slots)});
				end
			end
			pedl_pkg::MODE_12BPP, pedl_pkg::MODE_16BPP: begin
				if (depth_cfg == pedl_pkg::MODE_12BPP)
					word = {4'h0, e.red[7:4], e.green[7:4], e.blue[7:4]};
				else
					word = {e.red[7:3], e.green[7:2], e.blue[7:3]};
				if (swap_cfg) word = {word[7:0], word[15:8]};
				lookup_expect_q.push_back('{word: word, last: 1'b1});
			end
			default: begin
				// 8 bpp and the unused codes produce nothing.
			end
		endcase
	endfunction

	// Input side: tracks register writes, predicts on each accepted entry and
	// offers the next pending entry unless it idles this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			depth_cfg = pedl_pkg::MODE_16BPP;
			invert_cfg = 1'b0;
			swap_cfg = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pedl_pkg::CFG_DEPTH_MODE:  depth_cfg = cfg_data[2:0];
					pedl_pkg::CFG_GRAY_INVERT: invert_cfg = cfg_data[0];
					pedl_pkg::CFG_SWAP_BYTES:  swap_cfg = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_lookup(s_tdata);
				entries_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (entry_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata <= entry_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: checks each transfer and throttles m_tready, including the
	// long hold-off that lets the block fill up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lookup_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected lookup word %h last %b",
							$realtime, m_tdata, m_tlast);
				end else begin
					result_due = lookup_expect_q.pop_front();
					words_checked++;
					if (m_tdata !== result_due.word || m_tlast !== result_due.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: lookup word %h last %b, expected %h last %b",
								$realtime, m_tdata, m_tlast, result_due.word,
								result_due.last);
					end
				end
			end
			if (hold_served != hold_req) begin
				hold_served = hold_req;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("No transfer for %0d cycles, %0d words still outstanding.",
					stall_cycles, lookup_expect_q.size());
				$display("Regression FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Both tasks below are called just after a rising edge.
	task automatic cfg_write(input logic [pedl_pkg::CFG_INDEX_W-1:0] idx,
			input logic [pedl_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// The spare index is written last, so a decoding fault there would show up
	// in the words of the following phase.
	task automatic apply_settings(input logic [2:0] mode, input logic inv, input logic swap);
		cfg_write(pedl_pkg::CFG_DEPTH_MODE, mode);
		cfg_write(pedl_pkg::CFG_GRAY_INVERT, {2'($urandom), inv});
		cfg_write(pedl_pkg::CFG_SWAP_BYTES, {2'($urandom), swap});
		cfg_write(CFG_UNUSED_INDEX, 3'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Entries that give no result may still be inside the block when the last
	// word has arrived, hence the settling pause.
	task automatic wait_drained();
		while (entries_taken != entries_queued || lookup_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_entry(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		entry_q.push_back('{red: r, green: g, blue: b});
		entries_queued++;
	endtask

	// Leans towards the channel extremes and the 1 bpp threshold.
	function automatic logic [7:0] random_channel();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'($urandom_range(158, 163));
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [2:0]  phase_modes[13];
		logic [7:0]  c;
		int unsigned count, modes_seen;
		phase_modes = '{pedl_pkg::MODE_1BPP, pedl_pkg::MODE_2BPP,
			pedl_pkg::MODE_4BPP, pedl_pkg::MODE_8BPP, pedl_pkg::MODE_12BPP,
			pedl_pkg::MODE_16BPP, MODE_UNUSED_A, MODE_UNUSED_B,
			pedl_pkg::MODE_1BPP, pedl_pkg::MODE_2BPP, pedl_pkg::MODE_4BPP,
			pedl_pkg::MODE_12BPP, pedl_pkg::MODE_16BPP};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings first, then each depth with its corner cases.
		queue_entry(8'h00, 8'h00, 8'h00);
		queue_entry(8'hFF, 8'hFF, 8'hFF);
		queue_entry(8'h07, 8'h03, 8'h07);
		queue_entry(8'hF8, 8'hFC, 8'hF8);
		wait_drained();
		cfg_write(CFG_UNUSED_INDEX, 3'b111);
		cfg_valid <= 1'b0;
		queue_entry(8'h5A, 8'hA5, 8'h3C);
		wait_drained();
		apply_settings(pedl_pkg::MODE_12BPP, 1'b1, 1'b1);
		queue_entry(8'h12, 8'h34, 8'h56);
		queue_entry(8'hF0, 8'h0F, 8'hAA);
		wait_drained();
		// Lightness exactly at the threshold counts as dark.
		apply_settings(pedl_pkg::MODE_1BPP, 1'b0, 1'b0);
		queue_entry(8'd160, 8'd160, 8'd160);
		queue_entry(8'd161, 8'd161, 8'd161);
		queue_entry(8'd100, 8'd221, 8'd150);
		wait_drained();
		apply_settings(pedl_pkg::MODE_1BPP, 1'b1, 1'b0);
		queue_entry(8'd161, 8'd161, 8'd161);
		queue_entry(8'd160, 8'd160, 8'd160);
		wait_drained();
		// The byte swap must leave gray bytes alone.
		apply_settings(pedl_pkg::MODE_2BPP, 1'b0, 1'b1);
		queue_entry(8'h00, 8'h00, 8'h00);
		queue_entry(8'hFF, 8'hFF, 8'hFF);
		queue_entry(8'h40, 8'h40, 8'h40);
		wait_drained();
		apply_settings(pedl_pkg::MODE_4BPP, 1'b1, 1'b0);
		queue_entry(8'h00, 8'h00, 8'h00);
		queue_entry(8'hFF, 8'hFF, 8'hFF);
		queue_entry(8'h10, 8'h90, 8'h20);
		wait_drained();
		apply_settings(pedl_pkg::MODE_8BPP, 1'b0, 1'b1);
		queue_entry(8'hFF, 8'h00, 8'hFF);
		queue_entry(8'h00, 8'hFF, 8'h00);
		wait_drained();
		apply_settings(MODE_UNUSED_A, 1'b1, 1'b1);
		queue_entry(8'h80, 8'h80, 8'h80);
		wait_drained();
		apply_settings(MODE_UNUSED_B, 1'b0, 1'b0);
		queue_entry(8'h7F, 8'h7F, 8'h7F);
		wait_drained();

		// Random phases over every depth code, each with random flag settings.
		for (int p = 0; p < 13; p++) begin
			apply_settings(phase_modes[p], 1'($urandom), 1'($urandom));
			count = (phase_modes[p] == pedl_pkg::MODE_8BPP ||
				phase_modes[p] == MODE_UNUSED_A ||
				phase_modes[p] == MODE_UNUSED_B) ? SILENT_ENTRIES : PHASE_ENTRIES;
			if (p == 0) hold_req <= hold_req + 1;
			steady <= (p == 4 || p == 12);
			for (int i = 0; i < count; i++) begin
				// One phase stops feeding halfway until all words are back.
				if (p == 9 && i == count / 2) wait_drained();
				if ($urandom_range(5) == 0) begin
					c = random_channel();
					queue_entry(c, c, c);
				end else begin
					queue_entry(random_channel(), random_channel(), random_channel());
				end
			end
			wait_drained();
		end
		steady <= 1'b0;

		modes_seen = 0;
		for (int m = 0; m < 8; m++)
			if (mode_entries[m] != 0) modes_seen++;
		$display("Checked %0d lookup words from %0d palette entries under %0d settings.",
			words_checked, entries_taken, settings_used);
		$display("Depth codes exercised: %0d of 8, with a %0d-cycle output hold-off.",
			modes_seen, RX_HOLD_CYCLES);
		if (mismatches == 0 && lookup_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d words never arrived.",
				mismatches, lookup_expect_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
